// ===== src/block_buffer_pool_lru_macros.svh =====
// ============================================================================
// Buffer pool LRU manager - assertion macros
// Shared assertion wrappers; they compile to nothing when SYNTH is defined.
// ============================================================================
`ifndef BLOCK_BUFFER_POOL_LRU_MACROS_SVH
`define BLOCK_BUFFER_POOL_LRU_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and quiet during reset.
`define BBP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbp assertion failed");
// Next-cycle implication, sampled on clk and quiet during reset.
`define BBP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbp assertion failed");
`else
`define BBP_ASSERT_IMP(lbl, ante, cons)
`define BBP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/bbp_pkg.sv =====
// ============================================================================
// Buffer pool LRU manager - package
// Request and status codes, result record and sequencer states.
// ============================================================================
package bbp_pkg;

    // Fixed field widths of the stream payload.
    localparam int BLOCK_W = 14;
    localparam int SLOT_W  = 5;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_DIRTY  = 2'd2,
        REQ_FLUSH  = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BOUND = 2'd1,
        ST_MISS  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } fsm_t;

    // One result record.
    typedef struct packed {
        status_t                  status;
        logic [SLOT_W-1:0]        slot_index;
        logic                     writeback_valid;
        logic [SLOT_W-1:0]        writeback_slot;
        logic [BLOCK_W-1:0]       writeback_block;
        logic                     last;
    } res_t;

endpackage

// ===== src/bbp_ram.sv =====
// ============================================================================
// Buffer pool LRU manager - slot RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module bbp_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 30
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while not enabled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/bbp_seq.sv =====
// ============================================================================
// Buffer pool LRU manager - request sequencer
// Scans the slot RAM for in-range requests and dirty flushes, ages, picks victims, emits results.
// ============================================================================
`include "block_buffer_pool_lru_macros.svh"

module bbp_seq #(
    parameter int POOL_SLOTS = 32,
    parameter int DISK_SIZE  = 8192,
    parameter int AGE_WIDTH  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bbp_pkg::req_t                s_req,
    input  logic [bbp_pkg::BLOCK_W-1:0]  s_blk,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bbp_pkg::res_t                res
);
    import bbp_pkg::*;

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int ENT_W = BLOCK_W + AGE_WIDTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);
    localparam logic [BLOCK_W:0] DISK_LIM = (BLOCK_W + 1)'(DISK_SIZE);

    // Control state.
    fsm_t                  state_reg, state_next;
    logic [POOL_SLOTS-1:0] valid_reg, valid_next;
    logic [POOL_SLOTS-1:0] dirty_reg, dirty_next;
    logic                  a_active_reg, a_active_next;
    logic [IDX_W-1:0]      a_idx_reg, a_idx_next;
    logic                  b_valid_reg, b_valid_next;
    logic [IDX_W-1:0]      b_idx_reg, b_idx_next;

    // Request and scan trackers.
    req_t                  req_reg, req_next;
    logic [BLOCK_W-1:0]    blk_reg, blk_next;
    logic                  bound_reg, bound_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  best_seen_reg, best_seen_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [AGE_WIDTH-1:0]  best_age_reg, best_age_next;
    logic [BLOCK_W-1:0]    best_tag_reg, best_tag_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      found_idx_reg, found_idx_next;

    // RAM interface.
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [ENT_W-1:0]      rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;

    // Decoded read data and helpers.
    logic [BLOCK_W-1:0]    rd_tag;
    logic [AGE_WIDTH-1:0]  rd_age;
    logic [AGE_WIDTH-1:0]  aged;
    logic [POOL_SLOTS-1:0] vd;
    logic                  higher_vd;
    logic                  stall;
    logic                  advance;
    logic [IDX_W-1:0]      pick_idx;

    bbp_ram #(
        .DEPTH (POOL_SLOTS),
        .WIDTH (ENT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Entry fields and the saturating age increment.
    assign rd_tag = rd_data[AGE_WIDTH +: BLOCK_W];
    assign rd_age = rd_data[AGE_WIDTH-1:0];
    assign aged   = (rd_age == {AGE_WIDTH{1'b1}}) ? rd_age : rd_age + 1'b1;
    assign vd     = valid_reg & dirty_reg;

    // A flush result is the last one when no dirty slot lies above it.
    always_comb
    begin
        higher_vd = 1'b0;
        for (int j = 0; j < POOL_SLOTS; j++)
        begin
            if (vd[j] && (IDX_W'(j) > b_idx_reg))
            begin
                higher_vd = 1'b1;
            end
        end
    end

    // The scan halts while a flush writeback waits for the output register.
    assign stall    = b_valid_reg && (req_reg == REQ_FLUSH) && vd[b_idx_reg] && !res_ready;
    assign advance  = !stall;
    assign pick_idx = free_found_reg ? free_idx_reg : best_idx_reg;
    assign s_ready  = (state_reg == S_IDLE);

    // Next state, RAM accesses and results.
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        a_active_next   = a_active_reg;
        a_idx_next      = a_idx_reg;
        b_valid_next    = b_valid_reg;
        b_idx_next      = b_idx_reg;
        req_next        = req_reg;
        blk_next        = blk_reg;
        bound_next      = bound_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_seen_next  = best_seen_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        best_tag_next   = best_tag_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;

        rd_en     = 1'b0;
        rd_addr   = a_idx_reg;
        wr_en     = 1'b0;
        wr_addr   = b_idx_reg;
        wr_data   = {rd_tag, aged};
        res_valid = 1'b0;
        res       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_valid)
                begin
                    req_next        = s_req;
                    blk_next        = s_blk;
                    bound_next      = 1'b0;
                    free_found_next = 1'b0;
                    best_seen_next  = 1'b0;
                    found_next      = 1'b0;
                    a_idx_next      = '0;
                    a_active_next   = 1'b1;
                    b_valid_next    = 1'b0;
                    if (s_req == REQ_FLUSH)
                    begin
                        state_next = (|vd) ? S_SCAN : S_DONE;
                    end
                    else if ({1'b0, s_blk} >= DISK_LIM)
                    begin
                        bound_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Flush writebacks are offered straight from the read data.
                if (b_valid_reg && (req_reg == REQ_FLUSH) && vd[b_idx_reg])
                begin
                    res_valid           = 1'b1;
                    res.status          = ST_OK;
                    res.writeback_valid = 1'b1;
                    res.writeback_slot  = SLOT_W'(b_idx_reg);
                    res.writeback_block = rd_tag;
                    res.last            = !higher_vd;
                end

                if (advance)
                begin
                    // Read stage: fetch the next entry.
                    if (a_active_reg)
                    begin
                        rd_en        = 1'b1;
                        b_valid_next = 1'b1;
                        b_idx_next   = a_idx_reg;
                        a_idx_next   = a_idx_reg + 1'b1;
                        if (a_idx_reg == LAST_IDX)
                        begin
                            a_active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        b_valid_next = 1'b0;
                    end

                    // Evaluate stage: work on the entry just read.
                    if (b_valid_reg)
                    begin
                        case (req_reg) inside
                            REQ_ALLOC:
                            begin
                                if (valid_reg[b_idx_reg])
                                begin
                                    wr_en = 1'b1;
                                    if (!best_seen_reg || (aged > best_age_reg))
                                    begin
                                        best_seen_next = 1'b1;
                                        best_idx_next  = b_idx_reg;
                                        best_age_next  = aged;
                                        best_tag_next  = rd_tag;
                                    end
                                end
                                else if (!free_found_reg)
                                begin
                                    free_found_next = 1'b1;
                                    free_idx_next   = b_idx_reg;
                                end
                            end
                            REQ_LOOKUP, REQ_DIRTY:
                            begin
                                if (valid_reg[b_idx_reg] && (rd_tag == blk_reg) && !found_reg)
                                begin
                                    found_next     = 1'b1;
                                    found_idx_next = b_idx_reg;
                                end
                            end
                            default:
                            begin
                            end
                        endcase

                        if (b_idx_reg == LAST_IDX)
                        begin
                            if (req_reg == REQ_FLUSH)
                            begin
                                valid_next = '0;
                                dirty_next = '0;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                    end
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (bound_reg)
                begin
                    res.status = ST_BOUND;
                end
                else
                begin
                    case (req_reg) inside
                        REQ_ALLOC:
                        begin
                            res.status     = ST_OK;
                            res.slot_index = SLOT_W'(pick_idx);
                            if (!free_found_reg && dirty_reg[best_idx_reg])
                            begin
                                res.writeback_valid = 1'b1;
                                res.writeback_slot  = SLOT_W'(best_idx_reg);
                                res.writeback_block = best_tag_reg;
                            end
                        end
                        REQ_LOOKUP, REQ_DIRTY:
                        begin
                            if (found_reg)
                            begin
                                res.status     = ST_OK;
                                res.slot_index = SLOT_W'(found_idx_reg);
                            end
                            else
                            begin
                                res.status = ST_MISS;
                            end
                        end
                        default:
                        begin
                            // Flush with no dirty slot.
                            res.status = ST_OK;
                        end
                    endcase
                end

                // Commit the request once its result is taken.
                if (res_ready)
                begin
                    state_next = S_IDLE;
                    if (!bound_reg)
                    begin
                        case (req_reg) inside
                            REQ_ALLOC:
                            begin
                                wr_en                = 1'b1;
                                wr_addr              = pick_idx;
                                wr_data              = {blk_reg, {AGE_WIDTH{1'b0}}};
                                valid_next[pick_idx] = 1'b1;
                                dirty_next[pick_idx] = 1'b0;
                            end
                            REQ_DIRTY:
                            begin
                                if (found_reg)
                                begin
                                    dirty_next[found_idx_reg] = 1'b1;
                                end
                            end
                            REQ_FLUSH:
                            begin
                                valid_next = '0;
                                dirty_next = '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            a_active_reg <= 1'b0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            a_active_reg <= a_active_next;
            b_valid_reg  <= b_valid_next;
        end
    end

    // Payload and tracker registers.
    always_ff @(posedge clk)
    begin
        a_idx_reg      <= a_idx_next;
        b_idx_reg      <= b_idx_next;
        req_reg        <= req_next;
        blk_reg        <= blk_next;
        bound_reg      <= bound_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_seen_reg  <= best_seen_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        best_tag_reg   <= best_tag_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
    end

    // Only a flush offers results while the scan is running.
    `BBP_ASSERT_IMP(a_scan_result_is_flush, (state_reg == S_SCAN && res_valid), (req_reg == REQ_FLUSH))
    // The aging write never collides with the read of the same entry.
    `BBP_ASSERT_IMP(a_no_rw_collision, (rd_en && wr_en), (rd_addr != wr_addr))
    // A successful allocation leaves the chosen slot occupied.
    `BBP_ASSERT_NXT(a_alloc_fills_slot, (state_reg == S_DONE && res_ready && !bound_reg && req_reg == REQ_ALLOC), (valid_reg[$past(pick_idx)]))

endmodule

// ===== src/block_buffer_pool_lru.sv =====
// ============================================================================
// Buffer pool LRU manager - top level
// Slot bookkeeping for a buffer pool with least-recently-allocated victims.
// ============================================================================
// Requests enter on the slave stream (s_tvalid/s_tready/s_tdata) and results
// leave on the master stream (m_tvalid/m_tready/m_tdata/m_tlast); m_tlast
// marks the final result of a request. One request is worked on at a time.
// Allocate, lookup and set-dirty scan the slot RAM one entry per cycle, a rate
// set by the single read port of the slot RAM, and present the result after
// the scan; the next request is accepted once that result is taken into the
// output register. A block number out of range is answered without a scan. A
// flush with dirty slots scans the same way and emits one writeback per dirty
// slot as it passes it, pausing while a writeback waits; with nothing dirty
// it gives a single plain result without a scan.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the scan pauses at the next result until
// the output register is free, and no result is lost. Reset frees every slot
// at once and clears the dirty flags; there is no clearing pass.
// ============================================================================
module block_buffer_pool_lru #(
    parameter int POOL_SLOTS = 32,
    parameter int DISK_SIZE  = 8192,
    parameter int AGE_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: req_type[1:0], block_num[15:2]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: status[1:0], slot_index[6:2], writeback_valid[7],
    //          writeback_slot[12:8], writeback_block[26:13], zero[31:27]
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    import bbp_pkg::*;

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  m_tvalid_reg, m_tvalid_next;
    res_t  m_data_reg;

    bbp_seq #(
        .POOL_SLOTS (POOL_SLOTS),
        .DISK_SIZE  (DISK_SIZE),
        .AGE_WIDTH  (AGE_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_req     (req_t'(s_tdata[1:0])),
        .s_blk     (s_tdata[15:2]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: free when empty or being emptied in this cycle.
    assign res_ready     = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = (res_valid && res_ready) || (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    // Pack the result transaction.
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_data_reg.last;
    assign m_tdata  = {5'b0,
                       m_data_reg.writeback_block,
                       m_data_reg.writeback_slot,
                       m_data_reg.writeback_valid,
                       m_data_reg.slot_index,
                       m_data_reg.status};

endmodule

// ===== tb/sv/block_buffer_pool_lru_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Buffer pool LRU manager - stream testbench
// Drives allocate, lookup, set-dirty and flush requests into the slave stream
// and checks every result on the master stream against a slot model that is
// kept in step with each accepted request. A short scripted part covers the
// range limits, misses, duplicate blocks and flushes; random traffic then
// fills the pool past capacity so that clean and dirty slots are evicted.
// ============================================================================
module block_buffer_pool_lru_test;
    import bbp_pkg::*;

    localparam int POOL_SLOTS    = 32;
    localparam int DISK_CAPACITY = 8192;
    localparam int AGE_BITS      = 16;
    localparam logic [AGE_BITS-1:0] AGE_CEILING = '1;
    localparam int RANDOM_PHASES    = 3;
    localparam int ITEMS_PER_PHASE  = 66;
    localparam int DRAIN_CYCLES     = 40;

    // Results that can be read straight off the request.
    localparam res_t MISS_RES        = '{ST_MISS, 5'd0, 1'b0, 5'd0, 14'd0, 1'b1};
    localparam res_t BOUND_RES       = '{ST_BOUND, 5'd0, 1'b0, 5'd0, 14'd0, 1'b1};
    localparam res_t CLEAN_FLUSH_RES = '{ST_OK, 5'd0, 1'b0, 5'd0, 14'd0, 1'b1};
    localparam res_t FIRST_SLOT_RES  = '{ST_OK, 5'd0, 1'b0, 5'd0, 14'd0, 1'b1};
    localparam res_t NO_RES          = '0;

    // One row of the scripted part; want is used only where typed is set.
    typedef struct packed {
        req_t         req;
        logic [13:0]  blk;
        logic         typed;
        res_t         want;
    } script_row_t;

    localparam int SCRIPT_LEN = 21;

    script_row_t script [SCRIPT_LEN] = '{
        '{REQ_LOOKUP, 14'd0,     1'b1, MISS_RES},
        '{REQ_DIRTY,  14'd16383, 1'b1, BOUND_RES},
        '{REQ_FLUSH,  14'd0,     1'b1, CLEAN_FLUSH_RES},
        '{REQ_ALLOC,  14'd8192,  1'b1, BOUND_RES},
        '{REQ_ALLOC,  14'd16383, 1'b1, BOUND_RES},
        '{REQ_LOOKUP, 14'd8192,  1'b1, BOUND_RES},
        '{REQ_ALLOC,  14'd0,     1'b1, FIRST_SLOT_RES},
        '{REQ_ALLOC,  14'd8191,  1'b0, NO_RES},
        '{REQ_ALLOC,  14'd8191,  1'b0, NO_RES},
        '{REQ_LOOKUP, 14'd8191,  1'b0, NO_RES},
        '{REQ_DIRTY,  14'd8191,  1'b0, NO_RES},
        '{REQ_DIRTY,  14'd0,     1'b0, NO_RES},
        '{REQ_LOOKUP, 14'd5461,  1'b1, MISS_RES},
        '{REQ_DIRTY,  14'd10922, 1'b1, BOUND_RES},
        '{REQ_ALLOC,  14'd5461,  1'b0, NO_RES},
        '{REQ_DIRTY,  14'd5461,  1'b0, NO_RES},
        '{REQ_FLUSH,  14'd16383, 1'b0, NO_RES},
        '{REQ_FLUSH,  14'd0,     1'b1, CLEAN_FLUSH_RES},
        '{REQ_LOOKUP, 14'd8191,  1'b1, MISS_RES},
        '{REQ_ALLOC,  14'd4095,  1'b1, FIRST_SLOT_RES},
        '{REQ_ALLOC,  14'd8191,  1'b0, NO_RES}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // Slot model kept in step with accepted requests.
    logic                occupied [POOL_SLOTS];
    logic                modified [POOL_SLOTS];
    logic [13:0]         tag_of   [POOL_SLOTS];
    logic [AGE_BITS-1:0] age_of   [POOL_SLOTS];

    res_t pending_results [$];
    res_t fresh_results [$];

    int send_idle_pct = 14;
    int recv_idle_pct = 61;
    int fail_count = 0;
    int requests_sent = 0;
    int flushes_sent = 0;
    int results_checked = 0;
    int writebacks_seen = 0;

    block_buffer_pool_lru #(
        .POOL_SLOTS (POOL_SLOTS),
        .DISK_SIZE  (DISK_CAPACITY),
        .AGE_WIDTH  (AGE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Work out the results of one request and update the slot model.
    task automatic predict_request(input req_t req, input logic [13:0] blk);
        int   pick;
        int   i;
        res_t r;
        fresh_results.delete();
        if (req == REQ_FLUSH)
        begin
            for (i = 0; i < POOL_SLOTS; i++)
            begin
                if (occupied[i] && modified[i])
                begin
                    r = '{ST_OK, 5'd0, 1'b1, SLOT_W'(i), tag_of[i], 1'b0};
                    fresh_results.push_back(r);
                end
            end
            if (fresh_results.size() == 0)
                fresh_results.push_back(CLEAN_FLUSH_RES);
            else
            begin
                r = fresh_results.pop_back();
                r.last = 1'b1;
                fresh_results.push_back(r);
            end
            for (i = 0; i < POOL_SLOTS; i++)
            begin
                occupied[i] = 1'b0;
                modified[i] = 1'b0;
                age_of[i]   = '0;
            end
        end
        else if (blk >= DISK_CAPACITY)
            fresh_results.push_back(BOUND_RES);
        else if (req == REQ_ALLOC)
        begin
            r = '{ST_OK, 5'd0, 1'b0, 5'd0, 14'd0, 1'b1};
            for (i = 0; i < POOL_SLOTS; i++)
                if (occupied[i] && age_of[i] != AGE_CEILING)
                    age_of[i] = age_of[i] + 1'b1;
            pick = -1;
            for (i = 0; i < POOL_SLOTS && pick < 0; i++)
                if (!occupied[i])
                    pick = i;
            // Pool full: evict the oldest slot, lowest index on a tie.
            if (pick < 0)
            begin
                pick = 0;
                for (i = 1; i < POOL_SLOTS; i++)
                    if (age_of[i] > age_of[pick])
                        pick = i;
                if (modified[pick])
                begin
                    r.writeback_valid = 1'b1;
                    r.writeback_slot  = SLOT_W'(pick);
                    r.writeback_block = tag_of[pick];
                end
            end
            occupied[pick] = 1'b1;
            modified[pick] = 1'b0;
            tag_of[pick]   = blk;
            age_of[pick]   = '0;
            r.slot_index   = SLOT_W'(pick);
            fresh_results.push_back(r);
        end
        else
        begin
            pick = -1;
            for (i = 0; i < POOL_SLOTS && pick < 0; i++)
                if (occupied[i] && tag_of[i] == blk)
                    pick = i;
            if (pick < 0)
                fresh_results.push_back(MISS_RES);
            else
            begin
                if (req == REQ_DIRTY)
                    modified[pick] = 1'b1;
                r = '{ST_OK, SLOT_W'(pick), 1'b0, 5'd0, 14'd0, 1'b1};
                fresh_results.push_back(r);
            end
        end
    endtask

    // Present one request and wait for its transaction; then record what it should give.
    task automatic send_request(input req_t req, input logic [13:0] blk,
                                input logic typed, input res_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {blk, req};
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(req, blk);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (fresh_results[k])
                pending_results.push_back(fresh_results[k]);
        requests_sent++;
        if (req == REQ_FLUSH)
            flushes_sent++;
    endtask

    // Tag of a random occupied slot, or any in-range block if the pool is empty.
    function automatic logic [13:0] held_block();
        int start;
        int idx;
        start = $urandom_range(0, POOL_SLOTS - 1);
        for (int k = 0; k < POOL_SLOTS; k++)
        begin
            idx = (start + k) % POOL_SLOTS;
            if (occupied[idx])
                return tag_of[idx];
        end
        return 14'($urandom_range(0, DISK_CAPACITY - 1));
    endfunction

    // Unknown bits in the result count as a mismatch.
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Receiver back-pressure.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tdata[1:0]);
                check_field("slot_index", want.slot_index, m_tdata[6:2]);
                check_field("writeback_valid", want.writeback_valid, m_tdata[7]);
                check_field("writeback_slot", want.writeback_slot, m_tdata[12:8]);
                check_field("writeback_block", want.writeback_block, m_tdata[26:13]);
                check_field("padding", 0, m_tdata[31:27]);
                check_field("last", want.last, m_tlast);
                results_checked++;
                if (want.writeback_valid)
                    writebacks_seen++;
            end
        end
    end

    // Main sequence: reset, scripted requests, then random traffic in three phases of different idling.
    initial
    begin
        int         r;
        req_t       req;
        logic [13:0] blk;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            occupied[i] = 1'b0;
            modified[i] = 1'b0;
            tag_of[i]   = '0;
            age_of[i]   = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[n])
            send_request(script[n].req, script[n].blk, script[n].typed, script[n].want);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 14;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                // Each phase closes with a flush so that many dirty slots are written back.
                if (n == ITEMS_PER_PHASE - 1 || r >= 99)
                begin
                    req = REQ_FLUSH;
                    blk = 14'($urandom);
                end
                else if (r < 50)
                begin
                    req = REQ_ALLOC;
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        blk = held_block();
                    else if (r < 15)
                        blk = 14'(DISK_CAPACITY - 1);
                    else
                        blk = 14'($urandom_range(0, DISK_CAPACITY - 1));
                end
                else if (r < 68)
                begin
                    req = REQ_LOOKUP;
                    blk = held_block();
                end
                else if (r < 88)
                begin
                    req = REQ_DIRTY;
                    blk = held_block();
                end
                else if (r < 93)
                begin
                    req = req_t'($urandom_range(0, 2));
                    blk = 14'($urandom_range(DISK_CAPACITY, 16383));
                end
                else
                begin
                    // Any in-range block; mostly misses.
                    req = ($urandom_range(0, 1) != 0) ? REQ_LOOKUP : REQ_DIRTY;
                    blk = 14'($urandom_range(0, DISK_CAPACITY - 1));
                end
                send_request(req, blk, 1'b0, NO_RES);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, %0d of them flushes, under three back-pressure mixes.",
                 requests_sent, flushes_sent);
        $display("Checked %0d results, %0d of which carried a writeback.",
                 results_checked, writebacks_seen);
        if (fail_count == 0)
            $display("block_buffer_pool_lru test passed");
        else
            $display("block_buffer_pool_lru test failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("block_buffer_pool_lru test failed");
        $finish;
    end

endmodule
